>>> sv/sctg_pkg.sv
// ----------------------------------------------------------------------------
// sctg_pkg
// Shared types, register codes and the sine table generator for the
// single-channel sine tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sctg_pkg;

	localparam int PHASE_W    = 32;
	localparam int CC_W       = 4;
	localparam int ACT_W      = 3;
	localparam int CH_NUM_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 8;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST     = '0;
	localparam logic [CC_W-1:0]    CHANNEL_COUNT_RST  = 4'd2;
	localparam logic [ACT_W-1:0]   ACTIVE_CHANNEL_RST = '0;

	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP,
		CFG_CHANNEL_COUNT,
		CFG_ACTIVE_CHANNEL
	} cfg_idx_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [CC_W-1:0]    channel_count;
		logic [ACT_W-1:0]   active_channel;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               buffer_end;
	} phase_item_t;

	// Quarter-wave entry k: Q30 Taylor series (Horner, truncating), scaled to
	// full scale with rounding. Evaluated at elaboration only.
	function automatic logic [31:0] sine_entry(input int unsigned k,
			input int unsigned tbits, input int unsigned sbits);
		logic [63:0] fs;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		fs = (64'd1 << (sbits - 1)) - 64'd1;
		x  = (HALF_PI_Q30 * 64'(k)) >> tbits;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s * fs + (64'd1 << 29)) >> 30;
		if (v > fs) begin
			v = fs;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/single_channel_sine_tone_generator.sv
// ----------------------------------------------------------------------------
// single_channel_sine_tone_generator
// DDS sine oscillator: one frame request in, one result per channel out,
// tone on the active channel and zero elsewhere.
// ----------------------------------------------------------------------------
//  port group | dir | contents
//  s_*        | in  | frame request: tdata[0] restart, tlast buffer end
//  m_*        | out | per-channel result: tdata sample / channel, tlast frame
//             |     | last, tuser buffer end
//  cfg_*      | in  | register write: 0 phase_step, 1 channel_count,
//             |     | 2 active_channel
//
// A request passes the count, multiply, ROM read, frame load and output
// registers in that order before its first result appears; the count stage
// is written at the edge that takes it. The serializer sends one result a
// cycle while m_tready is high and loads the next frame's tone only as it
// sends the last channel of a frame; shorter bursts fill the pipeline.
// Reset loads register defaults, clears the sample count and empties the
// pipeline; the sine ROM is constant. A stall on m_tready backs up the
// pipeline stage by stage to s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module single_channel_sine_tone_generator #(
	parameter int MAX_CHANNELS    = 8,
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [sctg_pkg::IN_DATA_W-1:0]      s_tdata,  // [0] restart
	input  wire logic                                s_tlast,  // buffer_end_in
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// sample_value, channel_number, zero fill
	output logic [((SAMPLE_BITS + sctg_pkg::CH_NUM_W + 7) / 8) * 8 - 1:0] m_tdata,
	output logic                                     m_tlast,  // frame_last
	output logic                                     m_tuser,  // buffer_end_out
	input  wire logic                                cfg_wr_en,
	input  wire logic [sctg_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire logic [sctg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import sctg_pkg::*;

	localparam int OUT_DATA_W = ((SAMPLE_BITS + CH_NUM_W + 7) / 8) * 8;

	cfg_t                   cfg_q;
	logic                   ph_valid;
	logic                   ph_ready;
	phase_item_t            ph_item;
	logic                   sn_valid;
	logic                   sn_ready;
	logic [SAMPLE_BITS-1:0] sn_tone;
	logic                   sn_bend;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic [CH_NUM_W-1:0]    channel_number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step     <= PHASE_STEP_RST;
			cfg_q.channel_count  <= CHANNEL_COUNT_RST;
			cfg_q.active_channel <= ACTIVE_CHANNEL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_PHASE_STEP: begin
					cfg_q.phase_step <= cfg_wdata[PHASE_W-1:0];
				end
				CFG_CHANNEL_COUNT: begin
					cfg_q.channel_count <= cfg_wdata[CC_W-1:0];
				end
				CFG_ACTIVE_CHANNEL: begin
					cfg_q.active_channel <= cfg_wdata[ACT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sctg_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (cfg_q.phase_step),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.restart    (s_tdata[0]),
		.buffer_end (s_tlast),
		.out_valid  (ph_valid),
		.out_ready  (ph_ready),
		.out_item   (ph_item)
	);

	sctg_sine #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_sine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ph_valid),
		.in_ready   (ph_ready),
		.in_item    (ph_item),
		.out_valid  (sn_valid),
		.out_ready  (sn_ready),
		.tone       (sn_tone),
		.buffer_end (sn_bend)
	);

	sctg_frame #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (sn_valid),
		.in_ready       (sn_ready),
		.tone           (sn_tone),
		.buffer_end     (sn_bend),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.sample_value   (sample_value),
		.channel_number (channel_number),
		.frame_last     (m_tlast),
		.buffer_end_out (m_tuser)
	);

	assign m_tdata = OUT_DATA_W'({channel_number, sample_value});

endmodule

`default_nettype wire

>>> sv/sctg_phase.sv
// ----------------------------------------------------------------------------
// sctg_phase
// Sample counter and phase multiplier: count register, then phase =
// count * phase_step (mod 2^32) registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_phase (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [31:0]           phase_step,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  restart,
	input  wire logic                  buffer_end,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output sctg_pkg::phase_item_t      out_item
);
	import sctg_pkg::*;

	logic [PHASE_W-1:0] count_q;
	logic [PHASE_W-1:0] count_s1;
	logic               bend_s1;
	logic               valid_s1;
	logic               valid_s2;
	phase_item_t        item_s2;
	logic               ready_s2;
	logic [PHASE_W-1:0] count_op;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;
	assign count_op = restart ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				count_q <= count_op + 1'b1;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			count_s1 <= count_op;
			bend_s1  <= buffer_end;
		end
		if (ready_s2 && valid_s1) begin
			item_s2.phase      <= count_s1 * phase_step;
			item_s2.buffer_end <= bend_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

>>> sv/sctg_sine.sv
// ----------------------------------------------------------------------------
// sctg_sine
// Quarter-wave ROM lookup with quadrant folding; registered ROM read, then
// sign applied on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_sine #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire sctg_pkg::phase_item_t in_item,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [SAMPLE_BITS-1:0]     tone,
	output logic                       buffer_end
);
	import sctg_pkg::*;

	localparam int TABLE_SIZE = 2 ** SINE_TABLE_BITS;
	localparam int MAG_W      = SAMPLE_BITS - 1;

	typedef logic [MAG_W-1:0] rom_t [TABLE_SIZE];

	function automatic rom_t build_rom();
		rom_t rom;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			rom[k] = MAG_W'(sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS));
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS-1:0] addr;
	logic                       load;
	logic                       valid_s3;
	logic [MAG_W-1:0]           mag_s3;
	logic                       neg_s3;
	logic                       fs_s3;
	logic                       bend_s3;
	logic [MAG_W-1:0]           mag;
	logic [SAMPLE_BITS-1:0]     mag_ext;

	assign quad     = in_item.phase[31:30];
	assign idx      = in_item.phase[29 -: SINE_TABLE_BITS];
	// odd quadrants run the table backwards; index zero there is full scale
	assign addr     = quad[0] ? (SINE_TABLE_BITS'(0) - idx) : idx;
	assign in_ready = !valid_s3 || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_s3  <= SINE_ROM[addr];
			neg_s3  <= quad[1];
			fs_s3   <= quad[0] && (idx == '0);
			bend_s3 <= in_item.buffer_end;
		end
	end

	assign mag        = fs_s3 ? {MAG_W{1'b1}} : mag_s3;
	assign mag_ext    = {1'b0, mag};
	assign tone       = neg_s3 ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;
	assign buffer_end = bend_s3;
	assign out_valid  = valid_s3;

endmodule

`default_nettype wire

>>> sv/sctg_frame.sv
// ----------------------------------------------------------------------------
// sctg_frame
// Frame serializer: holds one tone sample and emits one result per channel
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sctg_frame #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sctg_pkg::cfg_t                cfg,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [SAMPLE_BITS-1:0]        tone,
	input  wire logic                          buffer_end,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [SAMPLE_BITS-1:0]             sample_value,
	output logic [sctg_pkg::CH_NUM_W-1:0]      channel_number,
	output logic                               frame_last,
	output logic                               buffer_end_out
);
	import sctg_pkg::*;

	logic [CC_W-1:0]        eff_cnt;
	logic                   busy_q;
	logic [CC_W-1:0]        ch_q;
	logic [SAMPLE_BITS-1:0] tone_s4;
	logic                   bend_s4;
	logic                   out_free;
	logic                   emit;
	logic                   last_ch;
	logic                   load;
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [CH_NUM_W-1:0]    chan_q;
	logic                   last_q;
	logic                   bend_q;

	always_comb begin
		if (cfg.channel_count == '0) begin
			eff_cnt = CC_W'(1);
		end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
			eff_cnt = CC_W'(MAX_CHANNELS);
		end else begin
			eff_cnt = cfg.channel_count;
		end
	end

	assign out_free = !valid_q || out_ready;
	assign emit     = busy_q && out_free;
	assign last_ch  = (ch_q == eff_cnt - 1'b1);
	assign in_ready = !busy_q || (emit && last_ch);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ch_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (emit) begin
				if (last_ch) begin
					busy_q <= 1'b0;
				end else begin
					ch_q <= ch_q + 1'b1;
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tone_s4 <= tone;
			bend_s4 <= buffer_end;
		end
		if (emit) begin
			sample_q <= (ch_q == {1'b0, cfg.active_channel}) ? tone_s4 : '0;
			chan_q   <= ch_q[CH_NUM_W-1:0];
			last_q   <= last_ch;
			bend_q   <= bend_s4;
		end
	end

	assign out_valid      = valid_q;
	assign sample_value   = sample_q;
	assign channel_number = chan_q;
	assign frame_last     = last_q;
	assign buffer_end_out = bend_q;

`ifndef ASSERT_OFF
	a_load_starts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && (ch_q == '0))
		else $error("frame load did not start at channel zero");

	a_mid_frame_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !last_q |=> valid_q)
		else $error("gap inside a frame");

	a_last_ends_or_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last_ch |=> !busy_q || (ch_q == '0))
		else $error("channel count ran past frame end");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the single-channel sine tone generator. Frame
// requests are streamed in under random idling and back-pressure, each
// accepted request is expanded into its per-channel samples by a local DDS
// predictor (own quarter-wave table, sample counter and register mirror),
// and every result leaving the block is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sctg_pkg::*;

	localparam int MAX_CH     = 8;
	localparam int TABLE_BITS = 10;
	localparam int SAMPLE_W   = 24;
	localparam int TABLE_N    = 1 << TABLE_BITS;
	localparam int M_DATA_W   = ((SAMPLE_W + CH_NUM_W + 7) / 8) * 8;
	localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
	// register index past the end of the map; writes must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic restart;
		logic buffer_end;
	} frame_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [CH_NUM_W-1:0] chan;
		logic                last;
		logic                bend;
	} chan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// register mirror and sample counter of the predictor
	logic [PHASE_W-1:0] tone_step  = PHASE_STEP_RST;
	logic [CC_W-1:0]    chan_count = CHANNEL_COUNT_RST;
	logic [ACT_W-1:0]   tone_chan  = ACTIVE_CHANNEL_RST;
	logic [31:0]        frame_count = '0;
	logic [SAMPLE_W-2:0] sine_rom [TABLE_N];

	frame_req_t   frame_reqs[$];
	chan_result_t pending_samples[$];
	frame_req_t   cur_req;
	int           frames_queued = 0;
	int           frames_taken  = 0;
	int           err_count     = 0;
	int           tx_idle_pct   = 26;
	int           rx_stall_pct  = 70;
	logic         hold_go = 1'b0;
	logic         rx_hold = 1'b0;

	single_channel_sine_tone_generator #(
		.MAX_CHANNELS    (MAX_CH),
		.SINE_TABLE_BITS (TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_W)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sin(pi/2 * k / N) in Q30 via truncating Horner form, scaled and rounded
	function automatic logic [SAMPLE_W-2:0] quarter_sine(input int unsigned k);
		logic [63:0] divs [6];
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		x  = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		for (int n = 0; n < 6; n++) begin
			t = ONE_Q30 - ((x2 * t) >> 30) / divs[n];
		end
		v = (((x * t) >> 30) * FULL_SCALE + (64'd1 << 29)) >> 30;
		if (v > FULL_SCALE) begin
			v = FULL_SCALE;
		end
		return v[SAMPLE_W-2:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] phase_to_sample(input logic [31:0] phase);
		logic [TABLE_BITS-1:0] idx;
		logic [SAMPLE_W-1:0]   mag;
		idx = phase[29 -: TABLE_BITS];
		if (phase[30]) begin
			// odd quadrants run the table backwards; index 0 lands on full scale
			mag = (idx == 0) ? FULL_SCALE[SAMPLE_W-1:0]
				: {1'b0, sine_rom[TABLE_N - int'(idx)]};
		end else begin
			mag = {1'b0, sine_rom[idx]};
		end
		if (phase[31]) begin
			mag = -mag;
		end
		return mag;
	endfunction

	function automatic void synth_frame(input frame_req_t req);
		int unsigned  n;
		logic [31:0]  phase;
		logic [SAMPLE_W-1:0] tone;
		chan_result_t r;
		n = (chan_count == 0) ? 1 : (chan_count > MAX_CH) ? MAX_CH : chan_count;
		if (req.restart) begin
			frame_count = '0;
		end
		phase = frame_count * tone_step;
		tone  = phase_to_sample(phase);
		for (int c = 0; c < n; c++) begin
			r.sample = (c == tone_chan) ? tone : '0;
			r.chan   = c[CH_NUM_W-1:0];
			r.last   = (c + 1 == n);
			r.bend   = req.buffer_end;
			pending_samples.push_back(r);
		end
		frame_count = frame_count + 32'd1;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
			err_count++;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				synth_frame(cur_req);
				frames_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (frame_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_req = frame_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(IN_DATA_W-1){1'b0}}, cur_req.restart};
					s_tlast  <= cur_req.buffer_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_samples.size() == 0) begin
					$error("unexpected item: sample %0h channel %0d",
						m_tdata[SAMPLE_W-1:0], m_tdata[SAMPLE_W +: CH_NUM_W]);
					err_count++;
				end else begin
					chan_result_t e;
					e = pending_samples.pop_front();
					check_field("sample_value", e.sample, m_tdata[SAMPLE_W-1:0]);
					check_field("channel_number", e.chan, m_tdata[SAMPLE_W +: CH_NUM_W]);
					check_field("frame_last", e.last, m_tlast);
					check_field("buffer_end_out", e.bend, m_tuser);
				end
			end
			m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off so the pipeline fills and s_tready drops
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic queue_frame(input logic restart, input logic bend);
		frame_req_t r;
		r.restart    = restart;
		r.buffer_end = bend;
		frame_reqs.push_back(r);
		frames_queued++;
	endtask

	task automatic wait_idle();
		while (frames_taken != frames_queued || pending_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_PHASE_STEP:     tone_step  = val[PHASE_W-1:0];
			CFG_CHANNEL_COUNT:  chan_count = val[CC_W-1:0];
			CFG_ACTIVE_CHANNEL: tone_chan  = val[ACT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic random_setting();
		logic [31:0] step;
		case ($urandom_range(0, 2))
			0: step = $urandom;
			1: step = $urandom_range(1, 32'h00ff_ffff);
			default: step = {2'($urandom_range(0, 3)), 30'd0} | ($urandom & 32'h3ff0_0000);
		endcase
		set_reg(CFG_PHASE_STEP, step);
		set_reg(CFG_CHANNEL_COUNT, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
			: $urandom_range(1, 8));
		set_reg(CFG_ACTIVE_CHANNEL, $urandom_range(0, 7));
		if ($urandom_range(0, 2) == 0) begin
			set_reg(CFG_SPARE, $urandom);
		end
	endtask

	initial begin
		for (int k = 0; k < TABLE_N; k++) begin
			sine_rom[k] = quarter_sine(k);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: zero step, two channels, tone on channel 0
		queue_frame(1'b0, 1'b1);
		queue_frame(1'b1, 1'b0);
		wait_idle();

		// quarter-turn step walks the quadrant boundaries
		set_reg(CFG_PHASE_STEP, 32'h4000_0000);
		set_reg(CFG_CHANNEL_COUNT, 4);
		set_reg(CFG_ACTIVE_CHANNEL, 1);
		queue_frame(1'b1, 1'b0);
		queue_frame(1'b0, 1'b0);
		queue_frame(1'b0, 1'b1);
		queue_frame(1'b0, 1'b0);
		queue_frame(1'b0, 1'b1);
		wait_idle();

		// largest step, zero channel count acts as a single channel
		set_reg(CFG_PHASE_STEP, 32'hffff_ffff);
		set_reg(CFG_CHANNEL_COUNT, 0);
		set_reg(CFG_ACTIVE_CHANNEL, 0);
		queue_frame(1'b1, 1'b1);
		queue_frame(1'b0, 1'b0);
		queue_frame(1'b0, 1'b1);
		wait_idle();

		// oversized count saturates to the maximum, tone on the top channel
		set_reg(CFG_PHASE_STEP, 32'h3ff0_0000);
		set_reg(CFG_CHANNEL_COUNT, 15);
		set_reg(CFG_ACTIVE_CHANNEL, 7);
		queue_frame(1'b1, 1'b0);
		queue_frame(1'b0, 1'b1);
		queue_frame(1'b0, 1'b0);
		queue_frame(1'b1, 1'b1);
		wait_idle();

		// active channel outside the frame gives silence; spare index ignored
		set_reg(CFG_CHANNEL_COUNT, 3);
		set_reg(CFG_ACTIVE_CHANNEL, 5);
		set_reg(CFG_SPARE, 32'hffff_ffff);
		queue_frame(1'b0, 1'b0);
		queue_frame(1'b0, 1'b1);
		queue_frame(1'b1, 1'b0);
		wait_idle();

		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				tx_idle_pct  = 70;
				rx_stall_pct = 26;
			end else if (seg == 4) begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			random_setting();
			if (seg == 0) begin
				hold_go = 1'b1;
			end
			for (int i = 0; i < 24; i++) begin
				queue_frame($urandom_range(0, 15) == 0, $urandom_range(0, 3) == 0);
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
